// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the caret box-code filter rtl
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, switched off while reset is high
`define CBF_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, switched off while reset is high
`define CBF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/cbf_pkg.sv =====
// shared types, character codes and the box-code mapping for the caret filter
// no dependencies
package cbf_pkg;

   localparam logic [7:0] CH_CARET = 8'h5E;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_BAR   = 8'h7C;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO  = 8'h30;

   // box codes
   localparam logic [7:0] CH_A   = 8'h41;
   localparam logic [7:0] CH_B   = 8'h42;
   localparam logic [7:0] CH_C   = 8'h43;
   localparam logic [7:0] CH_D   = 8'h44;
   localparam logic [7:0] CH_E   = 8'h45;
   localparam logic [7:0] CH_F   = 8'h46;
   localparam logic [7:0] CH_G   = 8'h47;
   localparam logic [7:0] CH_H   = 8'h48;
   localparam logic [7:0] CH_I   = 8'h49;
   localparam logic [7:0] CH_J   = 8'h4A;
   localparam logic [7:0] CH_K   = 8'h4B;
   localparam logic [7:0] CH_L   = 8'h4C;
   localparam logic [7:0] CH_ONE = 8'h31;
   localparam logic [7:0] CH_SIX = 8'h36;

   // smallest number of digits shown in a line prefix
   localparam int MIN_SHOWN = 3;

   // work queue between front and back, power of two
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   typedef struct packed {
      logic       keep;
      logic [7:0] ch;
   } cbf_char_type;

   // what one transaction asks the back end to write, besides the prefix digits
   typedef struct packed {
      logic       nl;
      logic       prefix;
      logic       char_v;
      logic [7:0] ch;
   } cbf_ctl_type;

   function automatic cbf_char_type cbf_map(input logic [7:0] c);
      cbf_char_type r;
      r.keep = 1'b1;
      r.ch   = c;
      unique case (c) inside
         CH_A, CH_B, CH_C, CH_D, CH_H: r.ch = CH_PLUS;
         CH_G, CH_I, CH_J:             r.ch = CH_DASH;
         CH_K, CH_L, CH_E, CH_F:       r.ch = CH_BAR;
         CH_ONE, CH_SIX:               r.keep = 1'b0;
         default:                      r.ch = c;
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/cbf_channel_if.sv =====
// valid/ready channel interfaces for the caret filter request and response
// no dependencies
interface cbf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;

   modport source (output valid, output in_char, input ready);
   modport sink   (input valid, input in_char, output ready);
endinterface

interface cbf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last_of_run;

   modport source (output valid, output out_char, output last_of_run, input ready);
   modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

// ===== hw/rtl/cbf_front.sv =====
// front end: accepts text bytes, tracks caret/run/line state, classifies each byte
// depends on cbf_pkg, cbf_channel_if and assert_macros.svh
`include "assert_macros.svh"

module cbf_front #(
   parameter int LINE_DIGITS = 5,
   parameter int IDX_W       = $clog2(LINE_DIGITS)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic                            csr_wr_data,
   cbf_req_if.sink                         req_chan,
   input  logic                            q_full,
   output logic                            q_push,
   output cbf_pkg::cbf_ctl_type            q_ctl,
   output logic [LINE_DIGITS-1:0][3:0]     q_digits,
   output logic [IDX_W-1:0]                q_top
);
   import cbf_pkg::*;

   logic [7:0]                  prev_ff, prev_in;
   logic                        run_ff, run_in;
   logic                        show_ff, show_in;
   logic [LINE_DIGITS-1:0][3:0] digits_ff, digits_in;

   logic                        accept;
   logic [7:0]                  c;
   logic                        is_caret, prev_caret, prev_nl;
   logic                        run_tog;
   logic                        count_one, all_nine, lower_nine;
   logic [LINE_DIGITS-1:0][3:0] digits_adv;
   logic [IDX_W-1:0]            top;
   logic                        do_prefix;
   cbf_char_type                mapped;

   assign c          = req_chan.in_char;
   assign req_chan.ready = !q_full;
   assign accept     = req_chan.valid && !q_full;
   assign is_caret   = (c == CH_CARET);
   assign prev_caret = (prev_ff == CH_CARET);
   assign prev_nl    = (prev_ff == CH_NL);
   assign run_tog    = run_ff ^ (is_caret && prev_caret);
   assign mapped     = cbf_map(c);

   // counter value one, saturation, bcd increment and leading digit
   always_comb begin
      count_one  = (digits_ff[0] == 4'd1);
      all_nine   = 1'b1;
      lower_nine = 1'b1;
      top        = IDX_W'(MIN_SHOWN - 1);
      digits_adv = digits_ff;
      for (int i = 0; i < LINE_DIGITS; i++) begin
         if (i > 0 && digits_ff[i] != 4'd0) begin
            count_one = 1'b0;
         end
         if (digits_ff[i] != 4'd9) begin
            all_nine = 1'b0;
         end
         if (lower_nine) begin
            digits_adv[i] = (digits_ff[i] >= 4'd9) ? 4'd0 : digits_ff[i] + 4'd1;
         end
         lower_nine = lower_nine && (digits_ff[i] >= 4'd9);
         if (digits_ff[i] != 4'd0 && i > MIN_SHOWN - 1) begin
            top = IDX_W'(i);
         end
      end
      if (all_nine) begin
         digits_adv = digits_ff;
      end
   end

   assign do_prefix = show_ff && (prev_nl || count_one);

   always_comb begin
      q_ctl.nl     = prev_nl;
      q_ctl.prefix = do_prefix;
      q_ctl.char_v = 1'b0;
      q_ctl.ch     = c;
      if (!is_caret && c != CH_NL) begin
         if (!prev_nl && (run_tog || prev_caret)) begin
            q_ctl.char_v = mapped.keep;
            q_ctl.ch     = mapped.ch;
         end else begin
            q_ctl.char_v = 1'b1;
         end
      end
   end

   assign q_digits = digits_ff;
   assign q_top    = top;
   assign q_push   = accept && (q_ctl.nl || q_ctl.prefix || q_ctl.char_v);

   always_comb begin
      prev_in   = prev_ff;
      run_in    = run_ff;
      digits_in = digits_ff;
      show_in   = csr_wr_en ? csr_wr_data : show_ff;
      if (accept) begin
         prev_in = c;
         run_in  = prev_nl ? 1'b0 : run_tog;
         if (do_prefix) begin
            digits_in = digits_adv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= '0;
         run_ff    <= 1'b0;
         show_ff   <= 1'b0;
         digits_ff <= {{(LINE_DIGITS - 1){4'd0}}, 4'd1};
      end else begin
         prev_ff   <= prev_in;
         run_ff    <= run_in;
         show_ff   <= show_in;
         digits_ff <= digits_in;
      end
   end

   `CBF_ASSERT_NEXT(a_nl_clears_run, clock, reset, accept && prev_nl, !run_ff, "run mode kept")

endmodule

// ===== hw/rtl/cbf_queue.sv =====
// short work queue that decouples the front end from the back end
// depends on cbf_pkg and assert_macros.svh
`include "assert_macros.svh"

module cbf_queue #(
   parameter int WIDTH = 36
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);
   import cbf_pkg::*;

   logic [WIDTH-1:0]  mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `CBF_ASSERT_IMPLY(a_no_overflow, clock, reset, full, !push, "push into a full queue")
   `CBF_ASSERT_IMPLY(a_no_underflow, clock, reset, !head_valid, !pop, "pop from an empty queue")

endmodule

// ===== hw/rtl/cbf_back.sv =====
// back end: expands one queued work entry into output bytes, one per cycle while the receiver is ready
// depends on cbf_pkg, cbf_channel_if and assert_macros.svh
`include "assert_macros.svh"

module cbf_back #(
   parameter int LINE_DIGITS = 5,
   parameter int IDX_W       = $clog2(LINE_DIGITS)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            head_valid,
   input  cbf_pkg::cbf_ctl_type            head_ctl,
   input  logic [LINE_DIGITS-1:0][3:0]     head_digits,
   input  logic [IDX_W-1:0]                head_top,
   output logic                            pop,
   cbf_rsp_if.source                       rsp_chan
);
   import cbf_pkg::*;

   localparam logic [2:0] PH_NL    = 3'd0;
   localparam logic [2:0] PH_DIGIT = 3'd1;
   localparam logic [2:0] PH_SP1   = 3'd2;
   localparam logic [2:0] PH_SP2   = 3'd3;
   localparam logic [2:0] PH_CHAR  = 3'd4;

   logic [2:0]       phase_ff, phase_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             started_ff, started_in;
   logic             valid_ff, valid_in;
   logic [7:0]       char_ff, char_in;
   logic             last_ff, last_in;

   logic [2:0]       start_phase, cur_phase, next_phase;
   logic [IDX_W-1:0] cur_idx, next_idx;
   logic [7:0]       cur_byte;
   logic             cur_last;
   logic             load;

   assign start_phase = head_ctl.nl ? PH_NL : (head_ctl.prefix ? PH_DIGIT : PH_CHAR);
   assign cur_phase   = started_ff ? phase_ff : start_phase;
   assign cur_idx     = started_ff ? idx_ff : head_top;

   always_comb begin
      cur_byte   = head_ctl.ch;
      cur_last   = 1'b1;
      next_phase = PH_CHAR;
      next_idx   = cur_idx;
      unique case (cur_phase)
         PH_NL: begin
            cur_byte   = CH_NL;
            cur_last   = !head_ctl.prefix && !head_ctl.char_v;
            next_phase = head_ctl.prefix ? PH_DIGIT : PH_CHAR;
            next_idx   = head_top;
         end
         PH_DIGIT: begin
            cur_byte   = CH_ZERO + {4'b0000, head_digits[cur_idx]};
            cur_last   = 1'b0;
            next_phase = (cur_idx == '0) ? PH_SP1 : PH_DIGIT;
            next_idx   = cur_idx - 1'b1;
         end
         PH_SP1: begin
            cur_byte   = CH_SPACE;
            cur_last   = 1'b0;
            next_phase = PH_SP2;
         end
         PH_SP2: begin
            cur_byte   = CH_SPACE;
            cur_last   = !head_ctl.char_v;
            next_phase = PH_CHAR;
         end
         default: begin
            cur_byte   = head_ctl.ch;
            cur_last   = 1'b1;
         end
      endcase
   end

   // output register takes a byte when empty or being drained
   assign load = head_valid && (!valid_ff || rsp_chan.ready);
   assign pop  = load && cur_last;

   always_comb begin
      phase_in   = phase_ff;
      idx_in     = idx_ff;
      started_in = started_ff;
      char_in    = char_ff;
      last_in    = last_ff;
      valid_in   = valid_ff && !rsp_chan.ready;
      if (load) begin
         valid_in   = 1'b1;
         char_in    = cur_byte;
         last_in    = cur_last;
         started_in = !cur_last;
         phase_in   = next_phase;
         idx_in     = next_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         started_ff <= 1'b0;
         phase_ff   <= PH_NL;
      end else begin
         valid_ff   <= valid_in;
         started_ff <= started_in;
         phase_ff   <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.out_char    = char_ff;
   assign rsp_chan.last_of_run = last_ff;

   `CBF_ASSERT_IMPLY(a_started_has_head, clock, reset, started_ff, head_valid, "expansion without a queued entry")

endmodule

// ===== hw/rtl/caret_box_code_text_filter.sv =====
// top level of the caret box-code text filter
// depends on cbf_pkg, cbf_channel_if, cbf_front, cbf_queue and cbf_back
//
// channel    | direction | payload                  | role
// -----------+-----------+--------------------------+------------------------------
// req_chan   | in        | in_char[7:0]             | text bytes, one per transaction
// rsp_chan   | out       | out_char[7:0], last_of_run | filtered bytes, last marks end
// csr_wr_*   | in        | csr_wr_data              | show_line_numbers register
//
// the front end takes one byte a cycle while the work queue has room
// a byte that makes one output byte passes through the work queue and then the back end output register
// a line start with numbering on makes up to LINE_DIGITS + 4 bytes in the back end,
// written by the single output register one byte a cycle while the receiver is ready
// the four-entry queue absorbs those bursts so the request side keeps streaming
// synchronous reset clears line state to line one; no clearing pass is needed
module caret_box_code_text_filter #(
   parameter int LINE_DIGITS = 5
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   cbf_req_if.sink    req_chan,
   cbf_rsp_if.source  rsp_chan
);
   import cbf_pkg::*;

   localparam int IDX_W  = $clog2(LINE_DIGITS);
   localparam int DESC_W = $bits(cbf_ctl_type) + 4 * LINE_DIGITS + IDX_W;

   // front end to queue
   logic                        f_push;
   cbf_ctl_type                 f_ctl;
   logic [LINE_DIGITS-1:0][3:0] f_digits;
   logic [IDX_W-1:0]            f_top;
   logic [DESC_W-1:0]           push_data;

   // queue to back end
   logic                        q_full;
   logic                        q_valid;
   logic                        q_pop;
   logic [DESC_W-1:0]           head_data;
   cbf_ctl_type                 h_ctl;
   logic [LINE_DIGITS-1:0][3:0] h_digits;
   logic [IDX_W-1:0]            h_top;

   // classification, caret/run state, line counter and the register
   cbf_front #(
      .LINE_DIGITS (LINE_DIGITS),
      .IDX_W       (IDX_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .q_full      (q_full),
      .q_push      (f_push),
      .q_ctl       (f_ctl),
      .q_digits    (f_digits),
      .q_top       (f_top)
   );

   // snapshot of the prefix digits travels with each entry
   assign push_data = {f_ctl, f_digits, f_top};

   cbf_queue #(
      .WIDTH (DESC_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (f_push),
      .push_data  (push_data),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head_data  (head_data)
   );

   assign {h_ctl, h_digits, h_top} = head_data;

   // byte sequencer and output register
   cbf_back #(
      .LINE_DIGITS (LINE_DIGITS),
      .IDX_W       (IDX_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (q_valid),
      .head_ctl    (h_ctl),
      .head_digits (h_digits),
      .head_top    (h_top),
      .pop         (q_pop),
      .rsp_chan    (rsp_chan)
   );

endmodule

// ===== sim/caret_box_code_text_filter_tb.sv =====
// testbench for caret_box_code_text_filter: text bytes go in on the request channel and
// every response transaction is checked against a directed row or a built-in model of the filter
// depends on cbf_pkg, cbf_channel_if and the filter rtl
module caret_box_code_text_filter_tb;
   import cbf_pkg::*;

   localparam int CLK_PERIOD       = 8;
   localparam int NUM_DIGITS       = 4;     // a width other than the default one
   localparam int SETTLE_CYCLES    = 64;    // queue of four, each up to NUM_DIGITS + 4 bytes
   localparam int WATCHDOG_LIMIT   = 2000;  // several times the long receiver hold-off
   localparam int LONG_HOLD        = 300;
   localparam int RANDOM_PER_PHASE = 80;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } out_byte_type;

   // one directed transaction; typed rows carry their result, the rest use the model
   typedef struct packed {
      logic [7:0] in_char;
      logic       numbering;
      logic       typed;
      logic       has_out;
      logic [7:0] out_char;
   } dir_row_type;

   localparam int DIR_COUNT = 26;
   localparam dir_row_type DIR_ROWS [DIR_COUNT] = '{
      '{CH_A,     1'b0, 1'b1, 1'b1, CH_A},     // box letter outside an escape passes
      '{8'h00,    1'b0, 1'b1, 1'b1, 8'h00},    // lowest byte
      '{8'hFF,    1'b0, 1'b1, 1'b1, 8'hFF},    // highest byte
      '{CH_CARET, 1'b0, 1'b1, 1'b0, 8'h00},    // caret is never echoed
      '{CH_A,     1'b0, 1'b1, 1'b1, CH_PLUS},  // escaped corner
      '{CH_CARET, 1'b0, 1'b1, 1'b0, 8'h00},
      '{CH_G,     1'b0, 1'b1, 1'b1, CH_DASH},  // escaped horizontal
      '{CH_CARET, 1'b0, 1'b1, 1'b0, 8'h00},
      '{CH_K,     1'b0, 1'b1, 1'b1, CH_BAR},   // escaped vertical
      '{CH_CARET, 1'b0, 1'b1, 1'b0, 8'h00},
      '{CH_ONE,   1'b0, 1'b1, 1'b0, 8'h00},    // escaped code one is dropped
      '{CH_CARET, 1'b0, 1'b1, 1'b0, 8'h00},
      '{CH_CARET, 1'b0, 1'b1, 1'b0, 8'h00},    // doubled caret switches the run on
      '{CH_H,     1'b0, 1'b1, 1'b1, CH_PLUS},
      '{CH_SIX,   1'b0, 1'b1, 1'b0, 8'h00},    // code six dropped inside the run
      '{CH_E,     1'b0, 1'b1, 1'b1, CH_BAR},
      '{"z",      1'b0, 1'b1, 1'b1, "z"},      // other bytes pass inside the run
      '{CH_NL,    1'b0, 1'b1, 1'b0, 8'h00},    // newline is held back
      '{CH_NL,    1'b0, 1'b1, 1'b1, CH_NL},    // newline after newline, written once
      '{CH_B,     1'b0, 1'b0, 1'b0, 8'h00},    // held newline, then the run is cleared
      '{"x",      1'b1, 1'b0, 1'b0, 8'h00},    // first line prefix with numbering on
      '{CH_NL,    1'b1, 1'b0, 1'b0, 8'h00},
      '{CH_CARET, 1'b1, 1'b0, 1'b0, 8'h00},    // caret after newline
      '{CH_C,     1'b1, 1'b0, 1'b0, 8'h00},
      '{CH_NL,    1'b1, 1'b0, 1'b0, 8'h00},
      '{CH_NL,    1'b1, 1'b0, 1'b0, 8'h00}     // blank line gets its own prefix
   };

   localparam logic [7:0] BOX_CODES [14] = '{
      CH_A, CH_B, CH_C, CH_D, CH_E, CH_F, CH_G, CH_H, CH_I, CH_J, CH_K, CH_L,
      CH_ONE, CH_SIX
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en;
   logic csr_wr_data;

   cbf_req_if req_if ();
   cbf_rsp_if rsp_if ();

   caret_box_code_text_filter #(.LINE_DIGITS(NUM_DIGITS)) uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // idling controls, shared between the sender, the receiver and the main sequence
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_request  = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;
   int fail_count    = 0;
   int bytes_sent    = 0;

   // filter model state: previous byte, run flag, line counter, numbering switch
   logic [7:0]   prev_byte;
   logic         run_on;
   logic [3:0]   line_no [NUM_DIGITS];  // index 0 is the least significant digit
   logic         numbering_on;
   out_byte_type step_out [$];         // bytes made by the latest transaction
   out_byte_type awaited_bytes [$];    // bytes still owed by the block, oldest first

   function automatic void clear_filter_state();
      prev_byte = 8'h00;
      run_on    = 1'b0;
      foreach (line_no[i]) line_no[i] = 4'd0;
      line_no[0]   = 4'd1;
      numbering_on = 1'b0;
   endfunction

   function automatic logic line_is_one();
      logic one;
      one = (line_no[0] == 4'd1);
      for (int i = 1; i < NUM_DIGITS; i++)
         if (line_no[i] != 4'd0) one = 1'b0;
      return one;
   endfunction

   function automatic logic line_saturated();
      logic sat;
      sat = 1'b1;
      foreach (line_no[i])
         if (line_no[i] != 4'd9) sat = 1'b0;
      return sat;
   endfunction

   function automatic void put_byte(input logic [7:0] ch);
      step_out.push_back('{ch: ch, last: 1'b0});
   endfunction

   // zero padded line number, two spaces, then on to the next line
   function automatic void put_line_prefix();
      int top;
      top = 0;
      for (int i = 0; i < NUM_DIGITS; i++)
         if (line_no[i] != 4'd0) top = i;
      if (top < MIN_SHOWN - 1) top = MIN_SHOWN - 1;
      for (int i = top; i >= 0; i--)
         put_byte(CH_ZERO + 8'(line_no[i]));
      put_byte(CH_SPACE);
      put_byte(CH_SPACE);
      if (!line_saturated()) begin
         for (int i = 0; i < NUM_DIGITS; i++) begin
            if (line_no[i] == 4'd9) begin
               line_no[i] = 4'd0;
            end else begin
               line_no[i] = line_no[i] + 4'd1;
               break;
            end
         end
      end
   endfunction

   function automatic void put_box_code(input logic [7:0] c);
      case (c)
         CH_A, CH_B, CH_C, CH_D, CH_H: put_byte(CH_PLUS);
         CH_G, CH_I, CH_J:             put_byte(CH_DASH);
         CH_K, CH_L, CH_E, CH_F:       put_byte(CH_BAR);
         CH_ONE, CH_SIX:               ;
         default:                      put_byte(c);
      endcase
   endfunction

   // bytes that one input byte makes, into step_out
   function automatic void filter_step(input logic [7:0] c);
      logic [7:0] prev;
      prev = prev_byte;
      step_out.delete();
      if (c == CH_CARET && prev == CH_CARET) run_on = ~run_on;
      if (prev == CH_NL) begin
         run_on = 1'b0;
         put_byte(CH_NL);
         if (numbering_on) put_line_prefix();
         if (c != CH_CARET && c != CH_NL) put_byte(c);
      end else begin
         if (numbering_on && line_is_one()) put_line_prefix();
         if (c != CH_CARET && c != CH_NL) begin
            if (run_on || prev == CH_CARET) put_box_code(c);
            else put_byte(c);
         end
      end
      prev_byte = c;
      if (step_out.size() != 0) step_out[step_out.size() - 1].last = 1'b1;
   endfunction

   // receiver: random stalls, plus a long hold-off counted here when asked for
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (reset || hold_left != 0) begin
         rsp_if.ready <= 1'b0;
         if (hold_left != 0) hold_left--;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // response check and watchdog
   always @(posedge clock) begin : rsp_check
      out_byte_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (awaited_bytes.size() == 0) begin
               $error("out_char: nothing expected, got %h", rsp_if.out_char);
               fail_count++;
            end else begin
               want = awaited_bytes.pop_front();
               if (rsp_if.out_char !== want.ch) begin
                  $error("out_char: expected %h, got %h", want.ch, rsp_if.out_char);
                  fail_count++;
               end
               if (rsp_if.last_of_run !== want.last) begin
                  $error("last_of_run: expected %b, got %b", want.last, rsp_if.last_of_run);
                  fail_count++;
               end
            end
         end
         if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // offer one byte; on acceptance, log what the block owes for it
   task automatic send_byte(input logic [7:0] c, input logic typed, input logic has_out,
                            input logic [7:0] typed_ch);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.in_char <= c;
      do @(posedge clock); while (!req_if.ready);
      filter_step(c);
      if (typed) begin
         if (has_out) awaited_bytes.push_back('{ch: typed_ch, last: 1'b1});
      end else begin
         foreach (step_out[i]) awaited_bytes.push_back(step_out[i]);
      end
      bytes_sent++;
   endtask

   task automatic send_text(input logic [7:0] c);
      send_byte(c, 1'b0, 1'b0, 8'h00);
   endtask

   // stop offering, let every owed byte arrive, then give the back end time to go quiet
   task automatic settle();
      req_if.valid <= 1'b0;
      while (awaited_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_numbering(input logic on);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= on;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      numbering_on = on;
   endtask

   function automatic logic [7:0] pick_box_code();
      return BOX_CODES[$urandom_range(13)];
   endfunction

   // mostly box-drawing text: words, escapes, runs and line breaks, some noise
   task automatic random_text(input int count);
      int stop_at;
      int kind;
      stop_at = bytes_sent + count;
      while (bytes_sent < stop_at) begin
         kind = $urandom_range(99);
         if (kind < 30) begin
            repeat ($urandom_range(1, 4)) send_text(8'($urandom_range(8'h20, 8'h7E)));
         end else if (kind < 55) begin
            send_text(CH_CARET);
            send_text(pick_box_code());
         end else if (kind < 75) begin
            send_text(CH_CARET);
            send_text(CH_CARET);
            repeat ($urandom_range(1, 6)) send_text(pick_box_code());
            // a run ends with another doubled caret or with a newline
            if ($urandom_range(1) != 0) begin
               send_text(CH_CARET);
               send_text(CH_CARET);
            end else begin
               send_text(CH_NL);
            end
         end else if (kind < 88) begin
            repeat ($urandom_range(1, 3)) send_text(CH_NL);
         end else begin
            send_text(8'($urandom));
         end
      end
   endtask

   initial begin
      req_if.valid   <= 1'b0;
      req_if.in_char <= 8'h00;
      csr_wr_en      <= 1'b0;
      csr_wr_data    <= 1'b0;
      clear_filter_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows; the register is rewritten whenever a row asks for another setting
      foreach (DIR_ROWS[i]) begin
         if (DIR_ROWS[i].numbering != numbering_on) begin
            settle();
            write_numbering(DIR_ROWS[i].numbering);
         end
         send_byte(DIR_ROWS[i].in_char, DIR_ROWS[i].typed, DIR_ROWS[i].has_out,
                   DIR_ROWS[i].out_char);
      end

      // numbering on, both sides flat out
      random_text(RANDOM_PER_PHASE);

      // numbering off, sender idle most of the time
      settle();
      write_numbering(1'b0);
      send_idle_pct = 73;
      random_text(RANDOM_PER_PHASE);

      // numbering on, receiver stalling; opens with a long hold-off to fill the block
      settle();
      write_numbering(1'b1);
      send_idle_pct = 0;
      stall_pct     = 73;
      hold_request  = LONG_HOLD;
      random_text(RANDOM_PER_PHASE);

      // both sides idling now and then
      settle();
      send_idle_pct = 31;
      stall_pct     = 31;
      random_text(RANDOM_PER_PHASE);

      // a few blank lines back to back, then a little more text
      settle();
      send_idle_pct = 0;
      stall_pct     = 0;
      repeat (3) send_text(CH_NL);
      random_text(12);

      settle();
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
